// File: hdl/trbc_pkg.sv
// Shared constants for the transformed rectangle bounds/clip core.
// Register indexes, reset values and matrix fixed-point format.
// No dependencies.
package trbc_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int MAT_BITS       = 32;
    localparam int MAT_FRAC_BITS  = 16;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_IDX_BITS   = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_XX = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHEAR_YX = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHEAR_XY = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_YY = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_W   = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_H   = 3'd7;

    localparam logic [MAT_BITS-1:0]      RST_SCALE  = 32'd65536;
    localparam logic [MAT_BITS-1:0]      RST_SHEAR  = 32'd0;
    localparam logic [CFG_DATA_BITS-1:0] RST_OFFSET = 32'd0;
    localparam logic [CFG_DATA_BITS-1:0] RST_VIEW_W = 32'd491520;
    localparam logic [CFG_DATA_BITS-1:0] RST_VIEW_H = 32'd276480;

    // tuser bit positions on the input stream
    localparam int TU_AFFINE_OK  = 0;
    localparam int TU_CLIP_EN    = 1;
    localparam int IN_TUSER_BITS = 2;

endpackage

// File: hdl/transformed_rect_bounds_clip_core.sv
// Affine-mapped bounding box of a rectangle, clipped to a clip rect and viewport.
// Top level; six-stage pipeline. Depends on trbc_pkg.
//
// Usage:
//   Input stream (s_axis): one source rectangle plus clip rectangle per transfer.
//     tuser carries affine_ok and clip_enable.
//   Output stream (m_axis): one result box per input transfer, in order.
//   Config port: i_cfg_wr_en/i_cfg_index/i_cfg_wdata writes matrix, offset and
//     viewport registers; write only while the pipeline is empty.
// Pipeline: o_m_axis_tvalid is the registered valid of the sixth stage.
//   Stages: corner sums, eight 32x24 products, corner sums with saturation,
//   min/max of corners, clip intersection, viewport intersection and size.
// Throughput: one item per cycle while the receiver is ready; the product stage
//   sets the cycle budget. Stall: a stage loads when empty or the next advances,
//   so bubbles collapse and input is still taken while a result waits; when all
//   six stages hold items and the receiver stalls, o_s_axis_tready drops.
// Reset: synchronous active-low; clears stage valids and loads register resets
//   (identity matrix, zero offset, 1920x1080 viewport).
module transformed_rect_bounds_clip_core #(
    parameter int COORD_BITS = trbc_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // cfg
    input  logic                                 i_cfg_wr_en,
    input  logic [trbc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [trbc_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    // input stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // rect_x, rect_y, rect_w, rect_h, clip_x, clip_y, clip_w, clip_h
    input  logic [((8*COORD_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    // affine_ok, clip_enable
    input  logic [trbc_pkg::IN_TUSER_BITS-1:0]   i_s_axis_tuser,
    // output stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // out_x, out_y, out_w, out_h, zero pad
    output logic [((4*COORD_BITS-2+7)/8)*8-1:0]  o_m_axis_tdata
);
    import trbc_pkg::*;

    localparam int CB      = COORD_BITS;
    localparam int PW      = CB + MAT_BITS;
    localparam int FW      = PW - MAT_FRAC_BITS;
    localparam int SW      = FW + 2;
    localparam int NSTG    = 6;

    localparam logic signed [SW-1:0] CMAX = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [SW-1:0] CMIN = ~CMAX;

    function automatic logic signed [CB-1:0] sat_c(input logic signed [SW-1:0] v);
        logic signed [CB-1:0] res;
        if (v > CMAX) begin
            res = CMAX[CB-1:0];
        end else if (v < CMIN) begin
            res = CMIN[CB-1:0];
        end else begin
            res = v[CB-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [FW-1:0] mul_floor(
        input logic signed [MAT_BITS-1:0] m,
        input logic signed [CB-1:0]       c
    );
        logic signed [PW-1:0] p;
        p = PW'(m) * PW'(c);
        return p[PW-1:MAT_FRAC_BITS];
    endfunction

    // configuration registers
    logic signed [MAT_BITS-1:0] r_scale_xx, r_shear_yx, r_shear_xy, r_scale_yy;
    logic signed [CB-1:0]       r_off_x, r_off_y;
    logic        [CB-2:0]       r_view_w, r_view_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_xx <= RST_SCALE;
            r_shear_yx <= RST_SHEAR;
            r_shear_xy <= RST_SHEAR;
            r_scale_yy <= RST_SCALE;
            r_off_x    <= RST_OFFSET[CB-1:0];
            r_off_y    <= RST_OFFSET[CB-1:0];
            r_view_w   <= RST_VIEW_W[CB-2:0];
            r_view_h   <= RST_VIEW_H[CB-2:0];
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SCALE_XX: r_scale_xx <= i_cfg_wdata[MAT_BITS-1:0];
                REG_SHEAR_YX: r_shear_yx <= i_cfg_wdata[MAT_BITS-1:0];
                REG_SHEAR_XY: r_shear_xy <= i_cfg_wdata[MAT_BITS-1:0];
                REG_SCALE_YY: r_scale_yy <= i_cfg_wdata[MAT_BITS-1:0];
                REG_OFFSET_X: r_off_x    <= i_cfg_wdata[CB-1:0];
                REG_OFFSET_Y: r_off_y    <= i_cfg_wdata[CB-1:0];
                REG_VIEW_W:   r_view_w   <= i_cfg_wdata[CB-2:0];
                REG_VIEW_H:   r_view_h   <= i_cfg_wdata[CB-2:0];
                default: ;
            endcase
        end
    end

    // stage valids and advance enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] n_vld;

    always_comb begin
        en[NSTG-1] = ~r_vld[NSTG-1] | i_m_axis_tready;
        for (int k = NSTG-2; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
        n_vld[0] = i_s_axis_tvalid;
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_s_axis_tready = en[0];

    // stage 1: far corner, clip far edges
    logic signed [CB-1:0] s_rx, s_ry, s_rw, s_rh, s_cx, s_cy, s_cw, s_ch;
    assign s_rx = i_s_axis_tdata[0*CB +: CB];
    assign s_ry = i_s_axis_tdata[1*CB +: CB];
    assign s_rw = i_s_axis_tdata[2*CB +: CB];
    assign s_rh = i_s_axis_tdata[3*CB +: CB];
    assign s_cx = i_s_axis_tdata[4*CB +: CB];
    assign s_cy = i_s_axis_tdata[5*CB +: CB];
    assign s_cw = i_s_axis_tdata[6*CB +: CB];
    assign s_ch = i_s_axis_tdata[7*CB +: CB];

    logic signed [CB-1:0] r1_x0, r1_y0, r1_x1, r1_y1, r1_cx, r1_cy;
    logic signed [CB:0]   r1_cr, r1_cb;
    logic                 r1_aff, r1_clip;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_x0   <= s_rx;
            r1_y0   <= s_ry;
            r1_x1   <= sat_c(SW'(s_rx) + SW'(s_rw));
            r1_y1   <= sat_c(SW'(s_ry) + SW'(s_rh));
            r1_cx   <= s_cx;
            r1_cy   <= s_cy;
            r1_cr   <= (CB+1)'(s_cx) + (CB+1)'(s_cw);
            r1_cb   <= (CB+1)'(s_cy) + (CB+1)'(s_ch);
            r1_aff  <= i_s_axis_tuser[TU_AFFINE_OK];
            r1_clip <= i_s_axis_tuser[TU_CLIP_EN];
        end
    end

    // stage 2: products, floored to the coordinate grid
    logic signed [FW-1:0] r2_fxx [2];
    logic signed [FW-1:0] r2_fyx [2];
    logic signed [FW-1:0] r2_fxy [2];
    logic signed [FW-1:0] r2_fyy [2];
    logic signed [CB-1:0] r2_cx, r2_cy;
    logic signed [CB:0]   r2_cr, r2_cb;
    logic                 r2_aff, r2_clip;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_fxx[0] <= mul_floor(r_scale_xx, r1_x0);
            r2_fxx[1] <= mul_floor(r_scale_xx, r1_x1);
            r2_fyx[0] <= mul_floor(r_shear_yx, r1_x0);
            r2_fyx[1] <= mul_floor(r_shear_yx, r1_x1);
            r2_fxy[0] <= mul_floor(r_shear_xy, r1_y0);
            r2_fxy[1] <= mul_floor(r_shear_xy, r1_y1);
            r2_fyy[0] <= mul_floor(r_scale_yy, r1_y0);
            r2_fyy[1] <= mul_floor(r_scale_yy, r1_y1);
            r2_cx     <= r1_cx;
            r2_cy     <= r1_cy;
            r2_cr     <= r1_cr;
            r2_cb     <= r1_cb;
            r2_aff    <= r1_aff;
            r2_clip   <= r1_clip;
        end
    end

    // stage 3: mapped corners (x0y0, x1y0, x1y1, x0y1)
    logic signed [CB-1:0] n3_px [4];
    logic signed [CB-1:0] n3_py [4];
    logic signed [CB-1:0] r3_px [4];
    logic signed [CB-1:0] r3_py [4];
    logic signed [CB-1:0] r3_cx, r3_cy;
    logic signed [CB:0]   r3_cr, r3_cb;
    logic                 r3_aff, r3_clip;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            logic [1:0] ci;
            logic       xi, yi;
            ci = 2'(c);
            xi = ci[0] ^ ci[1];
            yi = ci[1];
            n3_px[c] = sat_c(SW'(r2_fxx[xi]) + SW'(r2_fxy[yi]) + SW'(r_off_x));
            n3_py[c] = sat_c(SW'(r2_fyx[xi]) + SW'(r2_fyy[yi]) + SW'(r_off_y));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_px   <= n3_px;
            r3_py   <= n3_py;
            r3_cx   <= r2_cx;
            r3_cy   <= r2_cy;
            r3_cr   <= r2_cr;
            r3_cb   <= r2_cb;
            r3_aff  <= r2_aff;
            r3_clip <= r2_clip;
        end
    end

    // stage 4: bounding box
    logic signed [CB-1:0] n4_l, n4_r, n4_t, n4_b;
    logic signed [CB-1:0] lo_a, lo_b, hi_a, hi_b, to_a, to_b, bo_a, bo_b;

    always_comb begin
        lo_a = (r3_px[1] < r3_px[0]) ? r3_px[1] : r3_px[0];
        lo_b = (r3_px[3] < r3_px[2]) ? r3_px[3] : r3_px[2];
        hi_a = (r3_px[1] > r3_px[0]) ? r3_px[1] : r3_px[0];
        hi_b = (r3_px[3] > r3_px[2]) ? r3_px[3] : r3_px[2];
        to_a = (r3_py[1] < r3_py[0]) ? r3_py[1] : r3_py[0];
        to_b = (r3_py[3] < r3_py[2]) ? r3_py[3] : r3_py[2];
        bo_a = (r3_py[1] > r3_py[0]) ? r3_py[1] : r3_py[0];
        bo_b = (r3_py[3] > r3_py[2]) ? r3_py[3] : r3_py[2];
        n4_l = (lo_b < lo_a) ? lo_b : lo_a;
        n4_r = (hi_b > hi_a) ? hi_b : hi_a;
        n4_t = (to_b < to_a) ? to_b : to_a;
        n4_b = (bo_b > bo_a) ? bo_b : bo_a;
    end

    logic signed [CB-1:0] r4_l, r4_r, r4_t, r4_b, r4_cx, r4_cy;
    logic signed [CB:0]   r4_cr, r4_cb;
    logic                 r4_aff, r4_clip;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_l    <= n4_l;
            r4_r    <= n4_r;
            r4_t    <= n4_t;
            r4_b    <= n4_b;
            r4_cx   <= r3_cx;
            r4_cy   <= r3_cy;
            r4_cr   <= r3_cr;
            r4_cb   <= r3_cb;
            r4_aff  <= r3_aff;
            r4_clip <= r3_clip;
        end
    end

    // stage 5: clip intersection
    logic signed [CB-1:0] n5_l, n5_t;
    logic signed [CB:0]   n5_r, n5_b, r4_r_x, r4_b_x;

    always_comb begin
        r4_r_x = (CB+1)'(r4_r);
        r4_b_x = (CB+1)'(r4_b);
        n5_l = r4_l;
        n5_t = r4_t;
        n5_r = r4_r_x;
        n5_b = r4_b_x;
        if (r4_clip) begin
            n5_l = (r4_cx > r4_l) ? r4_cx : r4_l;
            n5_t = (r4_cy > r4_t) ? r4_cy : r4_t;
            n5_r = (r4_cr < r4_r_x) ? r4_cr : r4_r_x;
            n5_b = (r4_cb < r4_b_x) ? r4_cb : r4_b_x;
        end
    end

    logic signed [CB-1:0] r5_l, r5_t;
    logic signed [CB:0]   r5_r, r5_b;
    logic                 r5_aff;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_l   <= n5_l;
            r5_t   <= n5_t;
            r5_r   <= n5_r;
            r5_b   <= n5_b;
            r5_aff <= r4_aff;
        end
    end

    // stage 6: viewport intersection, sizes clamped at zero; full viewport if not affine_ok
    logic signed [CB-1:0] n6_l, n6_t;
    logic signed [CB:0]   n6_r, n6_b, vw_x, vh_x;
    logic signed [CB+1:0] d_w, d_h;
    logic signed [CB-1:0] n6_x, n6_y;
    logic        [CB-2:0] n6_w, n6_h;

    always_comb begin
        vw_x = $signed({2'b00, r_view_w});
        vh_x = $signed({2'b00, r_view_h});
        n6_l = r5_l[CB-1] ? '0 : r5_l;
        n6_t = r5_t[CB-1] ? '0 : r5_t;
        n6_r = (r5_r > vw_x) ? vw_x : r5_r;
        n6_b = (r5_b > vh_x) ? vh_x : r5_b;
        d_w  = (CB+2)'(n6_r) - (CB+2)'(n6_l);
        d_h  = (CB+2)'(n6_b) - (CB+2)'(n6_t);
        if (r5_aff) begin
            n6_x = n6_l;
            n6_y = n6_t;
            n6_w = d_w[CB+1] ? '0 : d_w[CB-2:0];
            n6_h = d_h[CB+1] ? '0 : d_h[CB-2:0];
        end else begin
            n6_x = '0;
            n6_y = '0;
            n6_w = r_view_w;
            n6_h = r_view_h;
        end
    end

    logic signed [CB-1:0] r6_x, r6_y;
    logic        [CB-2:0] r6_w, r6_h;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r6_x <= n6_x;
            r6_y <= n6_y;
            r6_w <= n6_w;
            r6_h <= n6_h;
        end
    end

    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[0 +: CB]          = r6_x;
        o_m_axis_tdata[CB +: CB]         = r6_y;
        o_m_axis_tdata[2*CB +: CB-1]     = r6_w;
        o_m_axis_tdata[3*CB-1 +: CB-1]   = r6_h;
    end

    assign o_m_axis_tvalid = r_vld[NSTG-1];

endmodule

// File: hdl/trbc_chk.sv
// Port-level checker for transformed_rect_bounds_clip_core, with its bind.
// Depends on trbc_pkg and the top-level port list.
module trbc_chk #(
    parameter int COORD_BITS = trbc_pkg::COORD_BITS_DEF
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_s_axis_tready,
    input logic                                 o_m_axis_tvalid,
    input logic                                 i_m_axis_tready,
    input logic [((4*COORD_BITS-2+7)/8)*8-1:0]  o_m_axis_tdata
);
    localparam int CB = COORD_BITS;

    // held result stays put until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("output changed while stalled");

    // pipeline is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // input is only refused when a finished result is being held back
    a_bp_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input refused without output stall");

    // result box never starts left of or above the viewport origin
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (!o_m_axis_tdata[CB-1] && !o_m_axis_tdata[2*CB-1]))
        else $error("result edge negative");

endmodule

bind transformed_rect_bounds_clip_core trbc_chk #(.COORD_BITS(COORD_BITS)) u_trbc_chk (.*);

// File: tb/sv/tb_transformed_rect_bounds_clip_core.sv
// Self-checking testbench for transformed_rect_bounds_clip_core: predicts each
// box from a shadow of the config registers and checks the output stream in order.
// Depends on trbc_pkg and the core; needs no other files.
`timescale 1ns / 100ps

module tb_transformed_rect_bounds_clip_core;
    import trbc_pkg::*;

    localparam int     CB        = COORD_BITS_DEF;
    localparam int     IN_BITS   = ((8*CB+7)/8)*8;
    localparam int     OUT_BITS  = ((4*CB-2+7)/8)*8;
    localparam longint COORD_MAX = 64'sd8388607;
    localparam longint COORD_MIN = -64'sd8388608;
    localparam int     CYC_LIMIT = 200000;

    typedef struct {
        logic signed [CB-1:0] rect_x, rect_y, rect_w, rect_h;
        logic                 affine_ok, clip_en;
        logic signed [CB-1:0] clip_x, clip_y, clip_w, clip_h;
    } t_rect_item;

    typedef struct {
        logic [CB-1:0] x, y;
        logic [CB-2:0] w, h;
    } t_box;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [IN_BITS-1:0]       s_tdata   = '0;
    logic [IN_TUSER_BITS-1:0] s_tuser   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_BITS-1:0]      m_tdata;

    logic [31:0]   cfg_regs [8];
    t_box          box_q [$];
    t_box          want_box;
    int            err_cnt   = 0;
    int unsigned   cyc       = 0;
    int            rx_hold   = 0;
    int            rx_mode   = 0;
    int            rx_left   = 0;
    int unsigned   rx_phase  = 0;
    int            tx_burst  = 0;
    bit            tx_steady = 1'b0;

    transformed_rect_bounds_clip_core #(
        .COORD_BITS(CB)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    always #5 clk = ~clk;

    initial begin
        cfg_regs[REG_SCALE_XX] = RST_SCALE;
        cfg_regs[REG_SHEAR_YX] = RST_SHEAR;
        cfg_regs[REG_SHEAR_XY] = RST_SHEAR;
        cfg_regs[REG_SCALE_YY] = RST_SCALE;
        cfg_regs[REG_OFFSET_X] = RST_OFFSET;
        cfg_regs[REG_OFFSET_Y] = RST_OFFSET;
        cfg_regs[REG_VIEW_W]   = RST_VIEW_W;
        cfg_regs[REG_VIEW_H]   = RST_VIEW_H;
    end

    // ---------------- prediction ----------------
    function automatic longint sat_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // two floored Q15.16 products plus offset, saturated
    function automatic longint map_axis(input longint ka, input longint a,
                                        input longint kb, input longint b,
                                        input longint off);
        return sat_coord(((ka * a) >>> MAT_FRAC_BITS) + ((kb * b) >>> MAT_FRAC_BITS) + off);
    endfunction

    function automatic longint lmax(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint lmin(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_box predict_box(input t_rect_item it);
        longint xx, yx, xy, yy, tx, ty, vw, vh;
        longint l, t, r, b, w, h, px, py;
        longint xs [2];
        longint ys [2];
        t_box   res;
        xx = longint'($signed(cfg_regs[REG_SCALE_XX]));
        yx = longint'($signed(cfg_regs[REG_SHEAR_YX]));
        xy = longint'($signed(cfg_regs[REG_SHEAR_XY]));
        yy = longint'($signed(cfg_regs[REG_SCALE_YY]));
        tx = longint'($signed(cfg_regs[REG_OFFSET_X][CB-1:0]));
        ty = longint'($signed(cfg_regs[REG_OFFSET_Y][CB-1:0]));
        vw = longint'(cfg_regs[REG_VIEW_W][CB-2:0]);
        vh = longint'(cfg_regs[REG_VIEW_H][CB-2:0]);
        if (!it.affine_ok) begin
            l = 0; t = 0; w = vw; h = vh;
        end else begin
            xs[0] = longint'(it.rect_x);
            ys[0] = longint'(it.rect_y);
            xs[1] = sat_coord(xs[0] + longint'(it.rect_w));
            ys[1] = sat_coord(ys[0] + longint'(it.rect_h));
            l = COORD_MAX; t = COORD_MAX; r = COORD_MIN; b = COORD_MIN;
            for (int i = 0; i < 2; i++) begin
                for (int j = 0; j < 2; j++) begin
                    px = map_axis(xx, xs[i], xy, ys[j], tx);
                    py = map_axis(yx, xs[i], yy, ys[j], ty);
                    l = lmin(l, px); r = lmax(r, px);
                    t = lmin(t, py); b = lmax(b, py);
                end
            end
            if (it.clip_en) begin
                l = lmax(l, longint'(it.clip_x));
                t = lmax(t, longint'(it.clip_y));
                r = lmin(r, longint'(it.clip_x) + longint'(it.clip_w));
                b = lmin(b, longint'(it.clip_y) + longint'(it.clip_h));
                r = lmax(r, l);
                b = lmax(b, t);
            end
            l = lmax(l, 0);  t = lmax(t, 0);
            r = lmin(r, vw); b = lmin(b, vh);
            w = lmax(0, r - l);
            h = lmax(0, b - t);
        end
        if (w > COORD_MAX) w = COORD_MAX;
        if (h > COORD_MAX) h = COORD_MAX;
        res.x = l[CB-1:0];
        res.y = t[CB-1:0];
        res.w = w[CB-2:0];
        res.h = h[CB-2:0];
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic t_rect_item mk_rect(
        input logic [CB-1:0] x, input logic [CB-1:0] y,
        input logic [CB-1:0] w, input logic [CB-1:0] h,
        input logic aff, input logic clip,
        input logic [CB-1:0] cx, input logic [CB-1:0] cy,
        input logic [CB-1:0] cw, input logic [CB-1:0] ch);
        t_rect_item it;
        it.rect_x = x;  it.rect_y = y;  it.rect_w = w;  it.rect_h = h;
        it.affine_ok = aff; it.clip_en = clip;
        it.clip_x = cx; it.clip_y = cy; it.clip_w = cw; it.clip_h = ch;
        return it;
    endfunction

    function automatic logic [CB-1:0] pick_edge();
        case ($urandom_range(0, 5))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'hFFFFFF;
            4:       return 24'h000001;
            default: return CB'($urandom());
        endcase
    endfunction

    // 0: any value, 1: around the viewport, 2: edge values
    function automatic logic [CB-1:0] rand_coord(input int kind);
        case (kind)
            0:       return CB'($urandom());
            1:       return CB'($urandom_range(0, 24'h8A000) - 24'h8000);
            default: return pick_edge();
        endcase
    endfunction

    // 0: any value, 1: within +-2.0, 2: edge values
    function automatic logic [31:0] rand_mat(input int kind);
        case (kind)
            0: return $urandom();
            1: return $urandom_range(0, 32'h40000) - 32'h20000;
            default: begin
                case ($urandom_range(0, 5))
                    0:       return 32'h7FFFFFFF;
                    1:       return 32'h80000000;
                    2:       return 32'h00000000;
                    3:       return 32'h00010000;
                    4:       return 32'hFFFF0000;
                    default: return 32'hFFFFFFFF;
                endcase
            end
        endcase
    endfunction

    // 0: noise, 1: typical scene rectangle, 2: edge values
    function automatic t_rect_item rand_rect(input int style);
        int kind;
        kind = (style == 0) ? 0 : (style == 1) ? 1 : 2;
        return mk_rect(rand_coord(kind), rand_coord(kind), rand_coord(kind), rand_coord(kind),
                       (style == 1) ? ($urandom_range(0, 15) != 0)
                                    : ($urandom_range(0, 1) != 0),
                       ($urandom_range(0, 1) != 0),
                       rand_coord(kind), rand_coord(kind), rand_coord(kind), rand_coord(kind));
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_cnt < 40)
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cyc, what, got, want);
        err_cnt++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_OFFSET_X, REG_OFFSET_Y: cfg_regs[idx] = {8'h00, val[CB-1:0]};
            REG_VIEW_W, REG_VIEW_H:     cfg_regs[idx] = {9'h000, val[CB-2:0]};
            default:                    cfg_regs[idx] = val;
        endcase
    endtask

    task automatic apply_config(input logic [31:0] sxx, input logic [31:0] syx,
                                input logic [31:0] sxy, input logic [31:0] syy,
                                input logic [31:0] ox, input logic [31:0] oy,
                                input logic [31:0] vw, input logic [31:0] vh);
        cfg_write(REG_SCALE_XX, sxx);
        cfg_write(REG_SHEAR_YX, syx);
        cfg_write(REG_SHEAR_XY, sxy);
        cfg_write(REG_SCALE_YY, syy);
        cfg_write(REG_OFFSET_X, ox);
        cfg_write(REG_OFFSET_Y, oy);
        cfg_write(REG_VIEW_W, vw);
        cfg_write(REG_VIEW_H, vh);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_rect(input t_rect_item it);
        logic [IN_TUSER_BITS-1:0] u;
        int                       gap;
        u = '0;
        u[TU_AFFINE_OK] = it.affine_ok;
        u[TU_CLIP_EN]   = it.clip_en;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= u;
        s_tdata  <= {it.clip_h, it.clip_w, it.clip_y, it.clip_x,
                     it.rect_h, it.rect_w, it.rect_y, it.rect_x};
        do @(posedge clk); while (!s_tready);
        box_q.insert(box_q.size(), predict_box(it));
        if (tx_steady) return;
        if (tx_burst > 0) begin
            tx_burst--;
        end else begin
            tx_burst = $urandom_range(0, 15);
            gap      = $urandom_range(1, 8);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic sender_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (box_q.size() != 0) @(posedge clk);
    endtask

    // ---------------- receiver and checker ----------------
    always @(negedge clk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  = rx_hold - 1;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) != 0);
                2:       m_tready <= (rx_phase % 5) < 3;
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (box_q.size() == 0) begin
                report_mismatch("box with nothing pending, out_x",
                                longint'($signed(m_tdata[23:0])), 0);
            end else begin
                want_box = box_q.pop_front();
                if (m_tdata[23:0] !== want_box.x)
                    report_mismatch("out_x", longint'($signed(m_tdata[23:0])),
                                    longint'($signed(want_box.x)));
                if (m_tdata[47:24] !== want_box.y)
                    report_mismatch("out_y", longint'($signed(m_tdata[47:24])),
                                    longint'($signed(want_box.y)));
                if (m_tdata[70:48] !== want_box.w)
                    report_mismatch("out_w", longint'(m_tdata[70:48]), longint'(want_box.w));
                if (m_tdata[93:71] !== want_box.h)
                    report_mismatch("out_h", longint'(m_tdata[93:71]), longint'(want_box.h));
            end
        end
    end

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- tests ----------------
    // reset register values: identity, zero offset, 1920x1080
    task automatic test_reset_config();
        send_rect(mk_rect(24'h123456, 24'hABCDEF, 24'h555555, 24'hAAAAAA, 1'b0, 1'b1,
                          24'h0F0F0F, 24'hF0F0F0, 24'h33CC33, 24'hCC33CC));
        send_rect(mk_rect(24'h001000, 24'h002000, 24'h003000, 24'h004000, 1'b1, 1'b0,
                          24'h0, 24'h0, 24'h0, 24'h0));
        send_rect(mk_rect(24'hFFF800, 24'h000100, 24'h002000, 24'h002000, 1'b1, 1'b1,
                          24'h000400, 24'h000000, 24'h001000, 24'h000800));
        // clip with negative width
        send_rect(mk_rect(24'h001000, 24'h001000, 24'h002000, 24'h002000, 1'b1, 1'b1,
                          24'h001100, 24'h001100, 24'hFFF000, 24'h000400));
        // clip disjoint from the box
        send_rect(mk_rect(24'h001000, 24'h001000, 24'h001000, 24'h001000, 1'b1, 1'b1,
                          24'h050000, 24'h030000, 24'h001000, 24'h001000));
        // negative source size
        send_rect(mk_rect(24'h005000, 24'h005000, 24'hFFE000, 24'hFFD000, 1'b1, 1'b0,
                          24'h0, 24'h0, 24'h0, 24'h0));
        // corner sums saturate high and low
        send_rect(mk_rect(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0,
                          24'h0, 24'h0, 24'h0, 24'h0));
        send_rect(mk_rect(24'h800000, 24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b1,
                          24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF));
        send_rect(mk_rect(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1,
                          24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        sender_idle();
        wait_drain();
    endtask

    // floor rounding, product and offset saturation, empty viewport
    task automatic test_fixed_point_edges();
        apply_config(32'hFFFE8000, 32'h00004000, 32'hFFFFC000, 32'h00018000,
                     32'h00050000, 32'h00001000, 32'h007FFFFF, 32'h007FFFFF);
        send_rect(mk_rect(24'h000001, 24'h000001, 24'h000003, 24'h000005, 1'b1, 1'b0,
                          24'h0, 24'h0, 24'h0, 24'h0));
        send_rect(mk_rect(24'h000200, 24'hFFFD00, 24'h007FFF, 24'h000100, 1'b1, 1'b1,
                          24'h000000, 24'h000000, 24'h7FFFFF, 24'h7FFFFF));
        send_rect(mk_rect(24'hFFFFFF, 24'hFFFFFF, 24'h000002, 24'h000002, 1'b1, 1'b0,
                          24'h0, 24'h0, 24'h0, 24'h0));
        sender_idle();
        wait_drain();
        apply_config(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                     32'hFF7FFFFF, 32'h00800000, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_rect(mk_rect(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0,
                          24'h0, 24'h0, 24'h0, 24'h0));
        send_rect(mk_rect(24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000, 1'b1, 1'b1,
                          24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF));
        send_rect(mk_rect(24'h000100, 24'h000100, 24'h000100, 24'h000100, 1'b1, 1'b0,
                          24'h0, 24'h0, 24'h0, 24'h0));
        send_rect(mk_rect(24'h000100, 24'h000100, 24'h000100, 24'h000100, 1'b0, 1'b0,
                          24'h0, 24'h0, 24'h0, 24'h0));
        sender_idle();
        wait_drain();
        apply_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h00800000, 32'h00800000, 32'h0, 32'h0);
        send_rect(mk_rect(24'h001000, 24'h001000, 24'h001000, 24'h001000, 1'b1, 1'b0,
                          24'h0, 24'h0, 24'h0, 24'h0));
        send_rect(mk_rect(24'h001000, 24'h001000, 24'h001000, 24'h001000, 1'b0, 1'b1,
                          24'h0, 24'h0, 24'h0, 24'h0));
        sender_idle();
        wait_drain();
    endtask

    // receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        apply_config(rand_mat(1), rand_mat(1), rand_mat(1), rand_mat(1),
                     32'(rand_coord(1)), 32'(rand_coord(1)), RST_VIEW_W, RST_VIEW_H);
        tx_steady = 1'b1;
        @(posedge clk);
        rx_hold = 60;
        repeat (30) send_rect(rand_rect(1));
        tx_steady = 1'b0;
        sender_idle();
        wait_drain();
    endtask

    task automatic test_random_phases();
        int style;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: apply_config(RST_SCALE, RST_SHEAR, RST_SHEAR, RST_SCALE,
                                $urandom_range(0, 24'h4000), $urandom_range(0, 24'h4000),
                                RST_VIEW_W, RST_VIEW_H);
                1: apply_config(rand_mat(1), rand_mat(1), rand_mat(1), rand_mat(1),
                                32'(rand_coord(1)), 32'(rand_coord(1)),
                                $urandom_range(0, 24'h80000), $urandom_range(0, 24'h80000));
                2: apply_config($urandom(), $urandom(), $urandom(), $urandom(),
                                $urandom(), $urandom(), $urandom(), $urandom());
                3: apply_config(rand_mat(2), rand_mat(2), rand_mat(2), rand_mat(2),
                                32'(pick_edge()), 32'(pick_edge()), 32'h007FFFFF, 32'h007FFFFF);
                4: apply_config(rand_mat(1), rand_mat(1), rand_mat(1), rand_mat(1),
                                32'(rand_coord(1)), 32'(rand_coord(1)), 32'h0,
                                $urandom_range(0, 24'h80000));
                default: apply_config(rand_mat(1), rand_mat(1), rand_mat(1), rand_mat(1),
                                      $urandom_range(0, 24'h8000) - 24'h8000,
                                      $urandom_range(0, 24'h8000) - 24'h8000,
                                      32'h007FFFFF, RST_VIEW_H);
            endcase
            tx_steady = (ph == 0) || (ph == 3);
            repeat (80) begin
                style = $urandom_range(0, 9);
                send_rect(rand_rect((style == 0) ? 0 : (style == 1) ? 2 : 1));
            end
            tx_steady = 1'b0;
            sender_idle();
            wait_drain();
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_config();
        test_fixed_point_edges();
        test_backpressure();
        test_random_phases();
        wait_drain();
        repeat (20) @(posedge clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
